// ===== rtl/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("assert failed");
`endif

// ===== rtl/gats_pkg.sv =====
package gats_pkg;
  localparam int unsigned CountDepthDef = 65536;
  localparam int unsigned PrimeDepthDef = 1024;
  localparam logic [1:0] ActLoadPrime = 2'd0;
  localparam logic [1:0] ActLoadPi    = 2'd1;
  localparam logic [1:0] ActRun       = 2'd2;
  localparam logic [1:0] ActUnused    = 2'd3;
  localparam logic [1:0] RegX     = 2'd0;
  localparam logic [1:0] RegY     = 2'd1;
  localparam logic [1:0] RegStart = 2'd2;
  localparam int unsigned SumW = 48;
endpackage

// ===== rtl/gats_divider.sv =====
// restoring divider, one quotient bit per cycle; zero divisor gives all ones
module gats_divider
  import gats_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [15:0] den_i,
  output logic        busy_o,
  output logic [31:0] quot_o
);
  logic [31:0] q_q, q_d;
  logic [16:0] r_q, r_d;
  logic [15:0] den_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        zero_q;
  logic [16:0] trial;
  logic [16:0] diff;

  always_comb begin
    trial = {r_q[15:0], q_q[31]};
    diff  = trial - {1'b0, den_q};
    q_d = q_q;
    r_d = r_q;
    cnt_d = cnt_q;
    if (cnt_q != 6'd0) begin
      cnt_d = cnt_q - 6'd1;
      if (trial >= {1'b0, den_q}) begin
        r_d = diff;
        q_d = {q_q[30:0], 1'b1};
      end else begin
        r_d = trial;
        q_d = {q_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 6'd0;
    end else if (start_i) begin
      cnt_q <= 6'd32;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= num_i;
      r_q <= 17'd0;
      den_q <= den_i;
      zero_q <= (den_i == 16'd0);
    end else begin
      q_q <= q_d;
      r_q <= r_d;
    end
  end

  assign busy_o = (cnt_q != 6'd0) || start_i;
  assign quot_o = zero_q ? 32'hFFFF_FFFF : q_q;
endmodule

// ===== rtl/gourdon_a_term_sum_unit.sv =====
// A-term sum unit. A load beat (prime or pi table entry) is taken while idle and
// the input stays ready for the next beat. A run forms cbrt(x) by a bit-wise
// search and reads pi at the root and at start_bound. Each outer prime then takes
// a serial division x/p_b, a square root of the quotient and the table reads
// around them. Each inner term takes a serial division plus the pi lookup and the
// add. A run ends in its single result beat, which is held until taken. The
// shared serial divider and root search set the rate.
module gourdon_a_term_sum_unit
  import gats_pkg::*;
#(
  parameter int unsigned COUNT_DEPTH = CountDepthDef,
  parameter int unsigned PRIME_DEPTH = PrimeDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // index [15:0], value [31:16]
  input  logic [1:0]  s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // sum
  output logic        m_axis_tuser,  // done_res
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  `include "assert_macros.svh"
  localparam int unsigned CW = $clog2(COUNT_DEPTH);
  localparam int unsigned PW = $clog2(PRIME_DEPTH);

  localparam logic [4:0] SIdle = 5'd0, SCb = 5'd1, SCb2 = 5'd2, SCbRd = 5'd3,
    SCbW = 5'd4, SStRd = 5'd5, SStW = 5'd6, SOut = 5'd7, SOPr = 5'd8,
    SOPrW = 5'd9, SODiv = 5'd10, SOSq = 5'd11, SOSq2 = 5'd12, SOSqRd = 5'd13,
    SOSqW = 5'd14, SInn = 5'd15, SIPrW = 5'd16, SIDiv = 5'd17, SITRd = 5'd18,
    SITW = 5'd19, SRes = 5'd20, SCbM = 5'd21, SOSqM = 5'd22;

  logic [4:0]  st_q;
  logic [31:0] x_q;
  logic [15:0] y_q, sb_q;
  logic [47:0] sum_q;
  logic [16:0] b_q;
  logic [15:0] j_q, lastb_q, lastj_q;
  logic [31:0] oq_q;
  logic [15:0] root_q, bit_q;
  logic [47:0] prod_q;
  logic [47:0] sq_q;

  logic [15:0] pmem [PRIME_DEPTH];
  logic [15:0] cmem [COUNT_DEPTH];
  logic [15:0] prd_q, crd_q;
  logic [PW-1:0] pa;
  logic [CW-1:0] ca;
  logic        div_start, div_busy;
  logic [31:0] div_num, div_q;
  logic [15:0] trial;

  logic [1:0]  act;
  logic [15:0] in_idx, in_val;
  assign act = s_axis_tuser;
  assign in_idx = s_axis_tdata[15:0];
  assign in_val = s_axis_tdata[31:16];

  function automatic logic [PW-1:0] pclamp(input logic [15:0] k);
    if ({16'd0, k} > PRIME_DEPTH - 1) pclamp = PW'(PRIME_DEPTH - 1);
    else pclamp = k[PW-1:0];
  endfunction
  function automatic logic [CW-1:0] cclamp(input logic [31:0] n);
    if (n > 32'(COUNT_DEPTH - 1)) cclamp = CW'(COUNT_DEPTH - 1);
    else cclamp = n[CW-1:0];
  endfunction
  function automatic logic [15:0] iclamp(input logic [15:0] k);
    if ({16'd0, k} > PRIME_DEPTH - 1) iclamp = 16'(PRIME_DEPTH - 1);
    else iclamp = k;
  endfunction

  assign s_axis_tready = (st_q == SIdle);
  assign cfg_ready_o = (st_q == SIdle);
  assign m_axis_tvalid = (st_q == SRes);
  assign m_axis_tdata = sum_q;
  assign m_axis_tuser = 1'b1;
  assign trial = root_q | bit_q;

  // memory addresses come from the sequencer
  always_comb begin
    pa = pclamp(j_q);
    ca = cclamp(oq_q);
    unique case (st_q)
      SCbRd:  ca = cclamp({16'd0, root_q});
      SStRd:  ca = cclamp({16'd0, sb_q});
      SOSqRd: ca = cclamp({16'd0, root_q});
      SOPr:   pa = pclamp(b_q[15:0]);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready && act == ActLoadPrime &&
        {16'd0, in_idx} < PRIME_DEPTH)
      pmem[in_idx[PW-1:0]] <= in_val;
    prd_q <= pmem[pa];
  end
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready && act == ActLoadPi &&
        {16'd0, in_idx} < COUNT_DEPTH)
      cmem[in_idx[CW-1:0]] <= in_val;
    crd_q <= cmem[ca];
  end

  assign div_start = (st_q == SOPrW) || (st_q == SIPrW);
  assign div_num = (st_q == SOPrW) ? x_q : oq_q;

  gats_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(prd_q),
    .busy_o(div_busy), .quot_o(div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      x_q <= 32'd1; y_q <= 16'd1; sb_q <= 16'd1;
      sum_q <= '0; b_q <= '0; j_q <= '0; oq_q <= '0;
      lastb_q <= '0; lastj_q <= '0; root_q <= '0; bit_q <= '0;
      prod_q <= '0; sq_q <= '0;
    end else begin
      unique case (st_q)
        SIdle: begin
          if (cfg_valid_i) begin
            unique case (cfg_index_i)
              RegX: x_q <= cfg_data_i;
              RegY: y_q <= cfg_data_i[15:0];
              RegStart: sb_q <= cfg_data_i[15:0];
              default: begin
              end
            endcase
          end
          if (s_axis_tvalid && act == ActRun) begin
            sum_q <= '0; root_q <= '0; bit_q <= 16'h0400; st_q <= SCb;
          end
        end
        // cube root: square first, multiply next
        SCb: begin sq_q <= 48'(trial * trial); st_q <= SCbM; end
        SCbM: begin prod_q <= 48'(sq_q[31:0] * trial); st_q <= SCb2; end
        SCb2: begin
          if (prod_q <= {16'd0, x_q}) root_q <= trial;
          bit_q <= bit_q >> 1;
          st_q <= (bit_q == 16'd1) ? SCbRd : SCb;
        end
        SCbRd: st_q <= SCbW;
        SCbW: begin lastb_q <= iclamp(crd_q); st_q <= SStRd; end
        SStRd: st_q <= SStW;
        // pi of 0xffff plus one leaves b above every prime index
        SStW: begin b_q <= {1'b0, crd_q} + 17'd1; st_q <= SOut; end
        SOut: st_q <= (b_q <= {1'b0, lastb_q}) ? SOPr : SRes;
        SOPr: st_q <= SOPrW;
        SOPrW: st_q <= SODiv;
        SODiv: if (!div_busy) begin
          oq_q <= div_q; root_q <= '0; bit_q <= 16'h8000; st_q <= SOSq;
        end
        SOSq: begin sq_q <= 48'(trial * trial); st_q <= SOSqM; end
        SOSqM: st_q <= SOSq2;
        SOSq2: begin
          if (sq_q <= {16'd0, oq_q}) root_q <= trial;
          bit_q <= bit_q >> 1;
          st_q <= (bit_q == 16'd1) ? SOSqRd : SOSq;
        end
        SOSqRd: st_q <= SOSqW;
        SOSqW: begin
          lastj_q <= iclamp(crd_q); j_q <= b_q[15:0] + 16'd1; st_q <= SInn;
        end
        SInn: begin
          if (j_q <= lastj_q) st_q <= SIPrW;
          else begin b_q <= b_q + 17'd1; st_q <= SOut; end
        end
        SIPrW: st_q <= SIDiv;
        SIDiv: if (!div_busy) begin oq_q <= div_q; prod_q <= {16'd0, oq_q}; st_q <= SITRd; end
        SITRd: st_q <= SITW;
        SITW: begin
          sum_q <= sum_q + ((oq_q < {16'd0, y_q}) ? {31'd0, crd_q, 1'b0} : {32'd0, crd_q});
          oq_q <= prod_q[31:0];
          j_q <= j_q + 16'd1;
          st_q <= SInn;
        end
        SRes: if (m_axis_tready) st_q <= SIdle;
        default: st_q <= SIdle;
      endcase
    end
  end

  `ASSERT_CLK(a_res_from_run, m_axis_tvalid |-> !s_axis_tready)
  `ASSERT_CLK(a_res_holds, (m_axis_tvalid && !m_axis_tready) |=> $stable(sum_q))
  `ASSERT_CLK(a_div_only_busy, div_busy |-> !s_axis_tready)
endmodule
